[hdl/ffpa_pkg.sv]
// Shared types, constants and codes of the first-fit page extent allocator.
package ffpa_pkg;
  localparam int MaxExtents = 64;
  localparam int IdxW = $clog2(MaxExtents);
  localparam int UsedW = $clog2(MaxExtents + 1);
  localparam int StartW = 16;
  localparam int LenW = 17;

  localparam logic [1:0] OpAlloc = 2'd0;
  localparam logic [1:0] OpFree = 2'd1;
  localparam logic [1:0] OpAdd = 2'd2;
  localparam logic [1:0] OpClear = 2'd3;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNoPages = 2'd1;
  localparam logic [1:0] StNoFit = 2'd2;
  localparam logic [1:0] StFull = 2'd3;

  localparam logic [LenW-1:0] LenMax = {LenW{1'b1}};

  typedef struct packed {
    logic [StartW-1:0] start;
    logic [LenW-1:0] len;
  } extent_t;

  // Per-cell write command, the same for every cell in one cycle.
  typedef struct packed {
    logic en;
    logic shift_up;
    logic shift_down;
    logic load;
    logic [IdxW-1:0] pos;
    logic [IdxW-1:0] tgt;
    extent_t value;
  } cell_cmd_t;

  function automatic logic [LenW-1:0] sat_add(input logic [LenW-1:0] a,
                                              input logic [LenW-1:0] b);
    logic [LenW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LenW] ? LenMax : s[LenW-1:0];
  endfunction
endpackage

[hdl/ffpa_cell.sv]
// One extent cell: holds an entry, shifts with its neighbours, flags fit and order.
module ffpa_cell (
  input  logic clk,
  input  logic [ffpa_pkg::IdxW-1:0] idx,
  input  ffpa_pkg::cell_cmd_t cmd,
  input  ffpa_pkg::extent_t lower,
  input  ffpa_pkg::extent_t upper,
  input  logic [ffpa_pkg::LenW-1:0] need,
  input  logic [ffpa_pkg::StartW-1:0] page,
  output ffpa_pkg::extent_t entry,
  output logic fits,
  output logic above
);
  import ffpa_pkg::*;

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      if (cmd.load && idx == cmd.tgt) begin
        entry <= cmd.value;
      end else if (cmd.shift_up && idx > cmd.pos) begin
        entry <= lower;
      end else if (cmd.shift_down && idx >= cmd.pos) begin
        entry <= upper;
      end
    end
  end

  assign fits = entry.len >= need;
  assign above = entry.start > page;
endmodule

[hdl/ffpa_ctrl.sv]
// Request sequencer: latches a transaction, searches the cells, writes back, answers.
module ffpa_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] op_in,
  input  logic [ffpa_pkg::StartW-1:0] page_in,
  input  logic [ffpa_pkg::LenW-1:0] cnt_in,
  input  ffpa_pkg::extent_t entries [ffpa_pkg::MaxExtents],
  input  logic [ffpa_pkg::MaxExtents-1:0] fits,
  input  logic [ffpa_pkg::MaxExtents-1:0] above,
  output ffpa_pkg::cell_cmd_t cmd,
  output logic [ffpa_pkg::LenW-1:0] need,
  output logic [ffpa_pkg::StartW-1:0] page,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] out_status,
  output logic [ffpa_pkg::StartW-1:0] out_start,
  output logic [ffpa_pkg::LenW-1:0] out_total
);
  import ffpa_pkg::*;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SFind = 2'd1;
  localparam logic [1:0] SExec = 2'd2;

  logic [1:0] state;
  logic [1:0] op;
  logic [UsedW-1:0] used;
  logic [LenW-1:0] total;
  logic [IdxW-1:0] hit;
  logic found;
  logic [UsedW-1:0] ipos;
  logic [IdxW-1:0] hit_next;
  logic found_next;
  logic [UsedW-1:0] ipos_next;
  extent_t lo_e, hi_e;
  logic [LenW:0] lo_end;
  logic low, high, full;
  logic [LenW-1:0] cnt_in_q;
  logic [StartW-1:0] page_q;

  assign need = cnt_in_q;
  assign page = page_q;

  always_comb begin
    hit_next = '0;
    found_next = 1'b0;
    ipos_next = used;
    for (int i = MaxExtents - 1; i >= 0; i--) begin
      if (UsedW'(i) < used && fits[i]) begin
        found_next = 1'b1;
        hit_next = IdxW'(i);
      end
      if (UsedW'(i) < used && above[i]) begin
        ipos_next = UsedW'(i);
      end
    end
  end

  assign in_ready = state == SIdle && !out_valid;
  assign full = used >= UsedW'(MaxExtents);

  always_comb begin
    lo_e = entries[(op == OpAlloc) ? hit : IdxW'(ipos - UsedW'(1))];
    hi_e = entries[IdxW'(ipos)];
    lo_end = {{(LenW-StartW){1'b0}}, lo_e.start} + {1'b0, lo_e.len};
    low = ipos != '0 && lo_end == (LenW+1)'(page_q);
    high = ipos < used &&
           (low ? lo_end + {1'b0, cnt_in_q}
                : (LenW+1)'(page_q) + {1'b0, cnt_in_q}) == (LenW+1)'(hi_e.start);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      used <= '0;
      total <= '0;
      out_valid <= 1'b0;
      cmd.en <= 1'b0;
    end else begin
      cmd.en <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        SIdle: begin
          if (in_valid && in_ready) begin
            op <= op_in;
            page_q <= page_in;
            cnt_in_q <= cnt_in;
            state <= SFind;
          end
        end
        SFind: begin
          hit <= hit_next;
          found <= found_next;
          ipos <= ipos_next;
          state <= SExec;
        end
        SExec: begin
          out_status <= StOk;
          out_start <= '0;
          cmd.shift_up <= 1'b0;
          cmd.shift_down <= 1'b0;
          cmd.load <= 1'b0;
          cmd.pos <= IdxW'(ipos);
          cmd.tgt <= IdxW'(ipos);
          cmd.value <= '{start: page_q, len: cnt_in_q};
          out_total <= total;
          if (op == OpClear) begin
            used <= '0;
            total <= '0;
            out_total <= '0;
          end else if (op == OpAlloc) begin
            if (cnt_in_q > total) begin
              out_status <= StNoPages;
            end else if (!found) begin
              out_status <= StNoFit;
            end else begin
              out_start <= lo_e.start;
              total <= total - cnt_in_q;
              out_total <= total - cnt_in_q;
              cmd.en <= 1'b1;
              if (lo_e.len > cnt_in_q) begin
                cmd.load <= 1'b1;
                cmd.tgt <= hit;
                cmd.value <= '{start: lo_e.start + cnt_in_q[StartW-1:0],
                               len: lo_e.len - cnt_in_q};
              end else begin
                cmd.shift_down <= 1'b1;
                cmd.pos <= hit;
                used <= used - UsedW'(1);
              end
            end
          end else if (cnt_in_q != '0) begin
            if (op == OpFree && (low || high)) begin
              cmd.en <= 1'b1;
              cmd.load <= 1'b1;
              total <= sat_add(total, cnt_in_q);
              out_total <= sat_add(total, cnt_in_q);
              if (low && high) begin
                cmd.tgt <= IdxW'(ipos - UsedW'(1));
                cmd.value <= '{start: lo_e.start,
                               len: sat_add(sat_add(lo_e.len, cnt_in_q), hi_e.len)};
                cmd.shift_down <= 1'b1;
                cmd.pos <= IdxW'(ipos);
                used <= used - UsedW'(1);
              end else if (low) begin
                cmd.tgt <= IdxW'(ipos - UsedW'(1));
                cmd.value <= '{start: lo_e.start, len: sat_add(lo_e.len, cnt_in_q)};
              end else begin
                cmd.value <= '{start: page_q, len: sat_add(cnt_in_q, hi_e.len)};
              end
            end else if (full) begin
              out_status <= StFull;
            end else begin
              cmd.en <= 1'b1;
              cmd.shift_up <= 1'b1;
              cmd.load <= 1'b1;
              used <= used + UsedW'(1);
              total <= sat_add(total, cnt_in_q);
              out_total <= sat_add(total, cnt_in_q);
            end
          end
          out_valid <= 1'b1;
          state <= SIdle;
        end
        default: state <= SIdle;
      endcase
    end
  end

  // A transaction is only taken when no answer is pending.
  a_no_accept_pending: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !out_valid) else $error("accept with pending result");
  a_used_range: assert property (@(posedge clk) disable iff (rst)
    used <= UsedW'(MaxExtents)) else $error("entry count out of range");
  a_one_answer: assert property (@(posedge clk) disable iff (rst)
    (state == SExec) |=> out_valid) else $error("missing result");
  a_free_no_shift_both: assert property (@(posedge clk) disable iff (rst)
    cmd.en |-> !(cmd.shift_up && cmd.shift_down)) else $error("conflicting shifts");
endmodule

[hdl/first_fit_page_extent_allocator.sv]
// Top level of the first-fit page extent allocator: cell chain and sequencer.
//  channel | direction | tdata fields (low bit first)             | tuser
//  s_axis  | in        | opcode[1:0] page_index[17:2] count[34:18] | -
//  m_axis  | out       | status[1:0] alloc_start[17:2] free_total[34:18] | -
// A request runs through cell search, decision, result with write back, and then the
// cycle that accepts the next one, which waits until the result has been taken.
// The search compares every cell in parallel; the write shifts the cell chain at most once.
// Reset empties the table at once; no clearing pass is run.
// A pending result stalls acceptance until it is taken.
module first_fit_page_extent_allocator (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [39:0] s_axis_tdata, // opcode, page_index, count, pad
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [39:0] m_axis_tdata  // status, alloc_start, free_total, pad
);
  import ffpa_pkg::*;

  cell_cmd_t cmd;
  extent_t entries [MaxExtents];
  logic [MaxExtents-1:0] fits, above;
  logic [LenW-1:0] need;
  logic [StartW-1:0] page;
  logic [1:0] st;
  logic [StartW-1:0] astart;
  logic [LenW-1:0] tot;

  for (genvar g = 0; g < MaxExtents; g++) begin : g_cell
    ffpa_cell u_cell (
      .clk(clk), .idx(IdxW'(g)), .cmd(cmd),
      .lower(entries[(g == 0) ? 0 : g - 1]),
      .upper(entries[(g == MaxExtents - 1) ? g : g + 1]),
      .need(need), .page(page),
      .entry(entries[g]), .fits(fits[g]), .above(above[g])
    );
  end

  ffpa_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .op_in(s_axis_tdata[1:0]), .page_in(s_axis_tdata[17:2]),
    .cnt_in(s_axis_tdata[34:18]),
    .entries(entries), .fits(fits), .above(above),
    .cmd(cmd), .need(need), .page(page),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_status(st), .out_start(astart), .out_total(tot)
  );

  assign m_axis_tdata = {5'd0, tot, astart, st};
endmodule

[bench/tb.sv]
// Self-checking testbench for the first-fit page extent allocator.
`timescale 1ns / 1ps

module tb;
  import ffpa_pkg::*;

  typedef struct {
    logic [1:0] status;
    logic [StartW-1:0] alloc_start;
    logic [LenW-1:0] free_total;
  } answer_t;

  class extent_ledger;
    logic [StartW-1:0] ext_start [MaxExtents];
    logic [LenW-1:0] ext_len [MaxExtents];
    int used;
    logic [LenW-1:0] free_cnt;
    answer_t pending[$];
    int errors;

    function void wipe();
      used = 0;
      free_cnt = '0;
    endfunction

    function logic [LenW-1:0] sadd(logic [LenW-1:0] a, logic [LenW-1:0] b);
      logic [LenW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[LenW] ? LenMax : s[LenW-1:0];
    endfunction

    function void put(int pos, logic [StartW-1:0] st, logic [LenW-1:0] ln);
      for (int i = used; i > pos; i--) begin
        ext_start[i] = ext_start[i-1];
        ext_len[i] = ext_len[i-1];
      end
      ext_start[pos] = st;
      ext_len[pos] = ln;
      used++;
    endfunction

    function void drop(int pos);
      for (int i = pos; i + 1 < used; i++) begin
        ext_start[i] = ext_start[i+1];
        ext_len[i] = ext_len[i+1];
      end
      used--;
    endfunction

    function void note_request(logic [1:0] op, logic [StartW-1:0] pg, logic [LenW-1:0] cnt);
      answer_t a;
      int pos, hit;
      bit low, high;
      logic [LenW:0] stop;
      a.status = StOk;
      a.alloc_start = '0;
      if (op == OpClear) begin
        wipe();
      end else if (op == OpAlloc) begin
        if (cnt > free_cnt) begin
          a.status = StNoPages;
        end else begin
          hit = -1;
          for (int i = 0; i < used; i++)
            if (hit < 0 && ext_len[i] >= cnt) hit = i;
          if (hit < 0) begin
            a.status = StNoFit;
          end else begin
            a.alloc_start = ext_start[hit];
            if (ext_len[hit] > cnt) begin
              ext_start[hit] = ext_start[hit] + cnt[StartW-1:0];
              ext_len[hit] = ext_len[hit] - cnt;
            end else begin
              drop(hit);
            end
            free_cnt = free_cnt - cnt;
          end
        end
      end else if (cnt != 0) begin
        pos = used;
        for (int i = used - 1; i >= 0; i--)
          if (ext_start[i] > pg) pos = i;
        if (op == OpAdd) begin
          if (used >= MaxExtents) a.status = StFull;
          else put(pos, pg, cnt);
        end else begin
          low = pos > 0 && ({1'b0, ext_start[pos-1]} + ext_len[pos-1]) == {2'b0, pg};
          stop = low ? {1'b0, ext_start[pos-1]} + ext_len[pos-1] + cnt : pg + cnt;
          high = pos < used && stop == {2'b0, ext_start[pos]};
          if (low && high) begin
            ext_len[pos-1] = sadd(sadd(ext_len[pos-1], cnt), ext_len[pos]);
            drop(pos);
          end else if (low) begin
            ext_len[pos-1] = sadd(ext_len[pos-1], cnt);
          end else if (high) begin
            ext_start[pos] = pg;
            ext_len[pos] = sadd(cnt, ext_len[pos]);
          end else if (used >= MaxExtents) begin
            a.status = StFull;
          end else begin
            put(pos, pg, cnt);
          end
        end
        if (a.status == StOk) free_cnt = sadd(free_cnt, cnt);
      end
      a.free_total = free_cnt;
      pending.push_back(a);
    endfunction

    function void check_answer(logic [39:0] d);
      answer_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction %h", d);
        return;
      end
      e = pending.pop_front();
      if (d[1:0] !== e.status || d[17:2] !== e.alloc_start || d[34:18] !== e.free_total) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp st=%0d start=%0d free=%0d got st=%0d start=%0d free=%0d",
                   e.status, e.alloc_start, e.free_total, d[1:0], d[17:2], d[34:18]);
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [39:0] s_axis_tdata, m_axis_tdata;
  extent_ledger board;
  int send_idle, recv_stall, quiet;
  logic [StartW-1:0] next_pg;

  first_fit_page_extent_allocator dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    board = new();
    board.wipe();
    board.errors = 0;
    send_idle = 0;
    recv_stall = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) board.check_answer(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (!rst && ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send(logic [1:0] op, logic [StartW-1:0] pg, logic [LenW-1:0] cnt);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, cnt, pg, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_request(op, pg, cnt);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_item();
    int r;
    logic [LenW-1:0] c;
    r = $urandom_range(99);
    c = ($urandom_range(9) == 0) ? LenW'($urandom_range(65536)) : LenW'($urandom_range(40));
    if (r < 2) send(OpClear, 16'($urandom), c);
    else if (r < 40) send(OpAlloc, 16'($urandom), c);
    else if (r < 75) begin
      send(OpFree, next_pg, c);
      next_pg = next_pg + c[15:0] + 16'($urandom_range(1) * $urandom_range(30));
    end else if (r < 85) send(OpFree, 16'($urandom), c);
    else send(OpAdd, ($urandom_range(1) ? next_pg : 16'($urandom)), c);
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    quiet = 0;
    next_pg = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send(OpAlloc, 0, 0);
    send(OpAlloc, 0, 1);
    send(OpFree, 100, 0);
    send(OpAdd, 200, 0);
    send(OpAdd, 16'hFFFF, 17'h10000);
    send(OpFree, 0, 17'h10000);
    send(OpFree, 16'h1000, 17'h1FFFF);
    send(OpAlloc, 0, 17'h1FFFF);
    send(OpAlloc, 0, 0);
    send(OpAlloc, 0, 17'h10001);
    send(OpClear, 0, 0);
    send(OpFree, 10, 10);
    send(OpFree, 30, 10);
    send(OpFree, 20, 10);
    send(OpFree, 40, 5);
    send(OpFree, 5, 5);
    send(OpAdd, 10, 3);
    send(OpAlloc, 0, 100);
    send(OpAlloc, 0, 3);
    send(OpAlloc, 0, 17'h1FFFF);
    send(OpClear, 16'hFFFF, 17'h1FFFF);
    for (int i = 0; i < 66; i++) send(OpAdd, 16'(i * 4), 2);
    send(OpFree, 16'd2, 2);
    send(OpFree, 16'd1000, 2);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 83 : 14) : 0;
      recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 83 : 14) : 0;
      send(OpClear, 0, 0);
      next_pg = 16'($urandom);
      for (int k = 0; k < 190; k++) random_item();
      drain();
    end
    send_idle = 0;
    recv_stall = 0;
    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
